/* rtl/fvc_pkg.sv */
// ----------------------------------------------------------------------------
// fvc_pkg
// Shared types, status codes, register indexes and the CRC-16 byte update
// for the frame validator.
// ----------------------------------------------------------------------------
package fvc_pkg;

	localparam int BYTE_W   = 8;
	localparam int STATUS_W = 3;
	localparam int CRC_W    = 16;
	localparam int CFG_IDX_W = 8;

	// status codes
	localparam logic [STATUS_W-1:0] ST_WAITING       = 3'd0;
	localparam logic [STATUS_W-1:0] ST_START_READING = 3'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_VALID     = 3'd2;
	localparam logic [STATUS_W-1:0] ST_WRONG_MODULE  = 3'd3;
	localparam logic [STATUS_W-1:0] ST_CRC_ERROR     = 3'd4;
	localparam logic [STATUS_W-1:0] ST_OK            = 3'd5;
	localparam logic [STATUS_W-1:0] ST_OVERFLOW      = 3'd6;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_START_MARK     = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_END_MARK       = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MODULE_ADDRESS = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_LENGTH     = 8'd3;

	localparam logic [BYTE_W-1:0] MIN_LENGTH_RESET = 8'd5;
	localparam logic [BYTE_W-1:0] POS_LAST         = 8'hFF;

	// CRC-16, poly 0x1021, MSB first
	localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

	typedef struct packed {
		logic [BYTE_W-1:0] start_mark;
		logic [BYTE_W-1:0] end_mark;
		logic [BYTE_W-1:0] module_address;
		logic [BYTE_W-1:0] min_length;
	} cfg_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [CRC_W-1:0]    crc_calculated;
		logic [CRC_W-1:0]    crc_received;
		logic [BYTE_W-1:0]   frame_length;
	} result_t;

	function automatic logic [CRC_W-1:0] crc16_byte(input logic [CRC_W-1:0] crc,
			input logic [BYTE_W-1:0] b);
		logic [CRC_W-1:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < BYTE_W; k++) begin
			if (c[CRC_W-1]) begin
				c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[CRC_W-2:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

/* rtl/fvc_tracker.sv */
// ----------------------------------------------------------------------------
// fvc_tracker
// Per-frame state (position, running CRC, trailer delay line, header bytes)
// and the end-of-frame decision.
// ----------------------------------------------------------------------------
module fvc_tracker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        step,
	input  logic [fvc_pkg::BYTE_W-1:0]  data_byte,
	input  logic                        last_byte,
	input  fvc_pkg::cfg_t               cfg,
	output fvc_pkg::result_t            result
);

	logic [fvc_pkg::BYTE_W-1:0] pos_q, pos_n;
	logic [fvc_pkg::CRC_W-1:0]  crc_q, crc_n;
	logic [fvc_pkg::BYTE_W-1:0] dly_q [3];
	logic [fvc_pkg::BYTE_W-1:0] dly_n [3];
	logic [fvc_pkg::BYTE_W-1:0] first_q, first_n;
	logic [fvc_pkg::BYTE_W-1:0] addr_q, addr_n;
	logic                       end_seen_q, end_seen_n;
	logic                       ovf_q, ovf_n;

	// next state for this byte
	always_comb begin
		pos_n      = pos_q;
		crc_n      = crc_q;
		dly_n      = dly_q;
		first_n    = first_q;
		addr_n     = addr_q;
		end_seen_n = end_seen_q;
		ovf_n      = ovf_q;
		if (!ovf_q && pos_q == fvc_pkg::POS_LAST) begin
			ovf_n = 1'b1;
		end else if (!ovf_q) begin
			if (pos_q == 8'd0) begin
				first_n = data_byte;
			end
			if (pos_q == 8'd1) begin
				addr_n = data_byte;
			end
			if (pos_q >= 8'd3 && data_byte == cfg.end_mark) begin
				end_seen_n = 1'b1;
			end
			if (pos_q >= 8'd4) begin
				crc_n = fvc_pkg::crc16_byte(crc_q, dly_q[2]);
			end
			dly_n[2] = dly_q[1];
			dly_n[1] = dly_q[0];
			dly_n[0] = data_byte;
			pos_n    = pos_q + 8'd1;
		end
	end

	// decision, used only when last_byte is set
	always_comb begin
		result              = '0;
		result.frame_length = pos_n;
		if (ovf_n) begin
			result.status       = fvc_pkg::ST_OVERFLOW;
			result.frame_length = fvc_pkg::POS_LAST;
		end else if (pos_n <= cfg.min_length) begin
			result.status = fvc_pkg::ST_WAITING;
		end else if (first_n != cfg.start_mark) begin
			result.status = fvc_pkg::ST_NOT_VALID;
		end else if (dly_n[0] != cfg.end_mark) begin
			result.status = fvc_pkg::ST_START_READING;
		end else if (addr_n != cfg.module_address || !end_seen_n) begin
			result.status = fvc_pkg::ST_WRONG_MODULE;
		end else begin
			result.crc_calculated = crc_n;
			result.crc_received   = {dly_n[1], dly_n[2]};
			result.status = (crc_n == {dly_n[1], dly_n[2]}) ?
				fvc_pkg::ST_OK : fvc_pkg::ST_CRC_ERROR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			crc_q      <= '0;
			dly_q      <= '{default: '0};
			first_q    <= '0;
			addr_q     <= '0;
			end_seen_q <= 1'b0;
			ovf_q      <= 1'b0;
		end else if (step) begin
			if (last_byte) begin
				pos_q      <= '0;
				crc_q      <= '0;
				dly_q      <= '{default: '0};
				first_q    <= '0;
				addr_q     <= '0;
				end_seen_q <= 1'b0;
				ovf_q      <= 1'b0;
			end else begin
				pos_q      <= pos_n;
				crc_q      <= crc_n;
				dly_q      <= dly_n;
				first_q    <= first_n;
				addr_q     <= addr_n;
				end_seen_q <= end_seen_n;
				ovf_q      <= ovf_n;
			end
		end
	end

	// overflow only ever latches once the position has saturated
	a_ovf_pos: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> pos_q == fvc_pkg::POS_LAST)
		else $error("overflow flag set below full position");

	// frame end clears the per-frame state
	a_frame_clear: assert property (@(posedge clk) disable iff (!arst_n)
		step && last_byte |=> pos_q == '0 && crc_q == '0 && !ovf_q && !end_seen_q)
		else $error("frame state not cleared after final byte");

	// end mark can only have been seen once position three is passed
	a_end_seen: assert property (@(posedge clk) disable iff (!arst_n)
		end_seen_q |-> pos_q >= 8'd4)
		else $error("end mark flag set too early in frame");

endmodule

/* rtl/frame_validator_crc16.sv */
// ----------------------------------------------------------------------------
// frame_validator_crc16
// Serial frame checker: marks, module address, length and CRC-16 trailer.
// ----------------------------------------------------------------------------
// Usage:
//  - s_axis carries one received frame byte per transaction; tlast flags the
//    final byte. Only the final byte produces a m_axis transaction, carrying
//    status, computed CRC, received CRC and frame length.
//  - cfg_* writes the four registers (start mark, end mark, module address,
//    minimum length). cfg_ready is always high; write only while idle.
//  - Throughput: one byte per cycle while no final byte is stalled. The CRC is
//    an unrolled 8-bit update, so a byte finishes in the single stage between
//    the input register and the result register.
//  - Path: an accepted final byte passes the input register, is then loaded
//    into the result register and is offered on m_axis from there.
//  - Stall: while a result waits on m_axis, bytes that give no result keep
//    flowing; a further final byte holds in the input register and
//    s_axis_tready drops until the waiting result is taken.
//  - Reset: arst_n clears the frame state, empties both registers and returns
//    the registers to start 0, end 0, address 0, min length 5.
// ----------------------------------------------------------------------------
module frame_validator_crc16 (
	input  logic        clk,
	input  logic        arst_n,
	// input byte stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic        s_axis_tlast,   // last_byte
	// result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,   // [2:0] status, [18:3] crc_calculated,
	                                    // [34:19] crc_received,
	                                    // [42:35] frame_length, [47:43] zero
	// register writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	fvc_pkg::cfg_t    cfg_q;
	fvc_pkg::result_t res;
	fvc_pkg::result_t out_q;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       out_valid_q;
	logic       out_free;
	logic       go_s1;

	// ---- register file ----
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_mark     <= '0;
			cfg_q.end_mark       <= '0;
			cfg_q.module_address <= '0;
			cfg_q.min_length     <= fvc_pkg::MIN_LENGTH_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				fvc_pkg::REG_START_MARK:     cfg_q.start_mark     <= cfg_data;
				fvc_pkg::REG_END_MARK:       cfg_q.end_mark       <= cfg_data;
				fvc_pkg::REG_MODULE_ADDRESS: cfg_q.module_address <= cfg_data;
				fvc_pkg::REG_MIN_LENGTH:     cfg_q.min_length     <= cfg_data;
				default: ;  // unknown index, write dropped
			endcase
		end
	end

	// ---- flow control ----
	// A byte in the input register moves on unless it is a final byte and
	// the result register is still occupied.
	assign out_free      = !out_valid_q || m_axis_tready;
	assign go_s1         = valid_s1 && (!last_s1 || out_free);
	assign s_axis_tready = !valid_s1 || go_s1;

	// ---- input register ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	// ---- frame state and decision ----
	fvc_tracker u_tracker (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (go_s1),
		.data_byte (byte_s1),
		.last_byte (last_s1),
		.cfg       (cfg_q),
		.result    (res)
	);

	// ---- result register ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && last_s1) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'b0, out_q.frame_length, out_q.crc_received,
	                        out_q.crc_calculated, out_q.status};

	// a held input byte is always a final byte blocked by an unread result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !go_s1 |-> last_s1 && out_valid_q && !m_axis_tready)
		else $error("input register stalled without cause");

	// an OK status means the two CRC fields agree
	a_ok_crc: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.status == fvc_pkg::ST_OK |->
			out_q.crc_calculated == out_q.crc_received)
		else $error("ok status with mismatching CRCs");

	// CRC fields are zero unless a CRC check was made
	a_crc_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.status != fvc_pkg::ST_OK &&
			out_q.status != fvc_pkg::ST_CRC_ERROR |->
			out_q.crc_calculated == '0 && out_q.crc_received == '0)
		else $error("CRC fields set without a CRC check");

endmodule

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for frame_validator_crc16: builds serial frames with
// valid and damaged marks, addresses, trailers and lengths, streams them with
// random gaps and back-pressure, and compares every status transaction with
// a cycle-free software predictor of the validator.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          IDLE_PCT      = 13;      // gap / stall rate in percent
	localparam int          ITEM_TARGET   = 1650;    // bytes offered in the phased part
	localparam int          HOLD_CYCLES   = 300;     // long receiver hold-off
	localparam int          SETTLE_CYCLES = 8;       // margin for the input and result registers to empty
	localparam int unsigned LIMIT_CYCLES  = 200000;
	localparam logic [7:0]  REG_SPARE     = 8'd200;  // not a register, write is dropped

	// kinds of frame damage
	typedef enum int {
		FLAW_NONE,
		FLAW_START,
		FLAW_ADDRESS,
		FLAW_END,
		FLAW_CRC,
		FLAW_GARBLED
	} flaw_t;

	typedef struct {
		logic [7:0] data;
		logic       last;
	} rx_byte_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;     // [7:0] data_byte
	logic        s_axis_tlast = 1'b0;   // last_byte
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;          // [2:0] status, [18:3] crc_calculated,
	                                    // [34:19] crc_received,
	                                    // [42:35] frame_length, [47:43] zero
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_index = '0;
	logic [7:0]  cfg_data = '0;

	frame_validator_crc16 i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// ------------------------------------------------------------------------
	// Stimulus and scoreboard storage
	// ------------------------------------------------------------------------
	rx_byte_t          byte_backlog[$];      // bytes waiting to be offered on s_axis
	fvc_pkg::result_t  pending_verdicts[$];  // statuses owed by the block, oldest first
	logic [7:0]        frame_buf[];          // frame under construction
	rx_byte_t          next_byte;
	fvc_pkg::result_t  want;
	int                error_count = 0;
	int unsigned       cycle_count = 0;
	int                hold_count = 0;
	bit                hold_phase = 1'b0;    // receiver goes quiet once while set
	bit                steady_flow = 1'b0;   // no gaps, no stalls while set

	// ------------------------------------------------------------------------
	// Predictor: register copy and per-frame state
	// ------------------------------------------------------------------------
	fvc_pkg::cfg_t mirror_cfg = '{start_mark: 8'h00, end_mark: 8'h00,
	                              module_address: 8'h00,
	                              min_length: fvc_pkg::MIN_LENGTH_RESET};
	logic [7:0]  frame_pos = '0;
	logic [15:0] crc_acc = '0;
	logic [7:0]  trailer [3] = '{default: 8'h00};  // [0] newest byte
	logic [7:0]  head_byte = '0;
	logic [7:0]  addr_byte = '0;
	logic        end_after_two = 1'b0;
	logic        too_long = 1'b0;

	// XMODEM CRC, one message bit at a time
	function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		logic        fb;
		c = crc;
		for (int i = 7; i >= 0; i--) begin
			fb = c[15] ^ b[i];
			c  = {c[14:0], 1'b0};
			if (fb) begin
				c = c ^ fvc_pkg::CRC_POLY;
			end
		end
		return c;
	endfunction

	// Advance the frame state by one accepted byte; on the final byte queue the
	// status the block owes and start afresh.
	function automatic void judge_byte(input logic [7:0] b, input logic last);
		fvc_pkg::result_t verdict;
		logic [7:0]       pos;
		pos = frame_pos;
		if (!too_long && pos == fvc_pkg::POS_LAST) begin
			too_long = 1'b1;
		end else if (!too_long) begin
			if (pos == 8'd0) head_byte = b;
			if (pos == 8'd1) addr_byte = b;
			if (pos >= 8'd3 && b == mirror_cfg.end_mark) end_after_two = 1'b1;
			// the CRC only sees a byte once three more have pushed it out
			if (pos >= 8'd4) crc_acc = crc_step(crc_acc, trailer[2]);
			trailer[2] = trailer[1];
			trailer[1] = trailer[0];
			trailer[0] = b;
			frame_pos  = pos + 8'd1;
		end
		if (!last) return;

		verdict = '0;
		verdict.frame_length = frame_pos;
		if (too_long) begin
			verdict.status       = fvc_pkg::ST_OVERFLOW;
			verdict.frame_length = 8'hFF;
		end else if (frame_pos <= mirror_cfg.min_length) begin
			verdict.status = fvc_pkg::ST_WAITING;
		end else if (head_byte != mirror_cfg.start_mark) begin
			verdict.status = fvc_pkg::ST_NOT_VALID;
		end else if (trailer[0] != mirror_cfg.end_mark) begin
			verdict.status = fvc_pkg::ST_START_READING;
		end else if (addr_byte != mirror_cfg.module_address || !end_after_two) begin
			verdict.status = fvc_pkg::ST_WRONG_MODULE;
		end else begin
			verdict.crc_calculated = crc_acc;
			verdict.crc_received   = {trailer[1], trailer[2]};
			verdict.status = (crc_acc == {trailer[1], trailer[2]}) ?
				fvc_pkg::ST_OK : fvc_pkg::ST_CRC_ERROR;
		end
		pending_verdicts.push_back(verdict);

		frame_pos     = '0;
		crc_acc       = '0;
		trailer       = '{default: 8'h00};
		head_byte     = '0;
		addr_byte     = '0;
		end_after_two = 1'b0;
		too_long      = 1'b0;
	endfunction

	// ------------------------------------------------------------------------
	// Frame construction
	// ------------------------------------------------------------------------
	// Well-formed frame for the current registers, then the chosen damage.
	// Payload bytes now and then equal the end mark.
	function automatic void build_frame(input int len, input flaw_t flaw);
		logic [15:0] c;
		int          i;
		frame_buf = new[len];
		for (i = 0; i < len; i++) begin
			frame_buf[i] = ($urandom_range(7) == 0) ? mirror_cfg.end_mark
			                                         : 8'($urandom_range(255));
		end
		if (flaw == FLAW_GARBLED) return;
		frame_buf[0] = mirror_cfg.start_mark;
		if (len > 1) frame_buf[1] = mirror_cfg.module_address;
		if (len >= 5) begin
			c = '0;
			for (i = 1; i <= len - 4; i++) c = crc_step(c, frame_buf[i]);
			frame_buf[len-3] = c[7:0];
			frame_buf[len-2] = c[15:8];
		end
		frame_buf[len-1] = mirror_cfg.end_mark;
		case (flaw)
			FLAW_START: begin
				frame_buf[0] ^= 8'($urandom_range(255, 1));
			end
			FLAW_ADDRESS: begin
				if (len > 1) frame_buf[1] ^= 8'($urandom_range(255, 1));
			end
			FLAW_END: begin
				frame_buf[len-1] ^= 8'($urandom_range(255, 1));
			end
			FLAW_CRC: begin
				if (len >= 5) frame_buf[len-3+$urandom_range(1)] ^= 8'(1 << $urandom_range(7));
			end
			default: ;
		endcase
	endfunction

	function automatic void push_bytes(input int lo, input int hi);
		for (int i = lo; i <= hi; i++) begin
			byte_backlog.push_back('{data: frame_buf[i], last: (i == frame_buf.size() - 1)});
		end
	endfunction

	// One short frame around the current minimum length; returns its size.
	function automatic int queue_random_frame();
		int    ml, len, r;
		flaw_t flaw;
		ml = int'(mirror_cfg.min_length);
		if ($urandom_range(99) < 8) begin
			len = $urandom_range((ml > 12) ? 12 : ml, 1);
		end else begin
			len = $urandom_range((ml + 14 > 255) ? 255 : ml + 14, ml + 1);
		end
		r = $urandom_range(99);
		if      (r < 55) flaw = FLAW_NONE;
		else if (r < 64) flaw = FLAW_START;
		else if (r < 73) flaw = FLAW_ADDRESS;
		else if (r < 82) flaw = FLAW_END;
		else if (r < 91) flaw = FLAW_CRC;
		else             flaw = FLAW_GARBLED;
		build_frame(len, flaw);
		push_bytes(0, len - 1);
		return len;
	endfunction

	function automatic logic [7:0] pick_mark();
		case ($urandom_range(9))
			0:       return 8'h00;
			1:       return 8'hFF;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	function automatic logic [7:0] pick_min();
		int r;
		r = $urandom_range(99);
		if (r < 15) return 8'd3;
		if (r < 75) return 8'($urandom_range(12, 3));
		return 8'($urandom_range(60, 3));
	endfunction

	// ------------------------------------------------------------------------
	// Register writes. Leaves cfg_valid high so writes can go back to back;
	// the caller lowers it after the last one.
	// ------------------------------------------------------------------------
	task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			fvc_pkg::REG_START_MARK:     mirror_cfg.start_mark     = val;
			fvc_pkg::REG_END_MARK:       mirror_cfg.end_mark       = val;
			fvc_pkg::REG_MODULE_ADDRESS: mirror_cfg.module_address = val;
			fvc_pkg::REG_MIN_LENGTH:     mirror_cfg.min_length     = val;
			default: ;
		endcase
	endtask

	task automatic set_config(input logic [7:0] sm, input logic [7:0] em,
			input logic [7:0] ma, input logic [7:0] ml);
		write_reg(fvc_pkg::REG_START_MARK, sm);
		write_reg(fvc_pkg::REG_END_MARK, em);
		write_reg(fvc_pkg::REG_MODULE_ADDRESS, ma);
		write_reg(fvc_pkg::REG_MIN_LENGTH, ml);
		cfg_valid <= 1'b0;
	endtask

	// Sender pause: everything offered, every status back, pipeline flushed.
	task automatic wait_drained();
		while (byte_backlog.size() != 0 || s_axis_tvalid || pending_verdicts.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Clock, reset and run limit
	// ------------------------------------------------------------------------
	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("%0t: timeout, %0d statuses still owed", $time, pending_verdicts.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Byte driver: predicts on each accepted transaction, then offers the next
	// byte unless a random gap is taken.
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			s_axis_tlast  <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				judge_byte(s_axis_tdata, s_axis_tlast);
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (byte_backlog.size() != 0
						&& (steady_flow || $urandom_range(99) >= IDLE_PCT)) begin
					next_byte = byte_backlog.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= next_byte.data;
					s_axis_tlast  <= next_byte.last;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Result receiver: random stalls, plus one long hold-off counted here so
	// the block backs up and drops s_axis_tready.
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (hold_phase && hold_count < HOLD_CYCLES) begin
			hold_count    <= hold_count + 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// ------------------------------------------------------------------------
	// Status monitor
	// ------------------------------------------------------------------------
	function automatic void check_field(input string what, input int unsigned exp_v,
			input int unsigned act_v);
		if (exp_v != act_v) begin
			$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, exp_v, act_v);
			error_count++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_verdicts.size() == 0) begin
				$display("%0t: unexpected status transaction, expected none, actual 0x%0h",
				         $time, m_axis_tdata);
				error_count++;
			end else begin
				want = pending_verdicts.pop_front();
				check_field("status",         32'(want.status),
				            32'(m_axis_tdata[2:0]));
				check_field("crc_calculated", 32'(want.crc_calculated),
				            32'(m_axis_tdata[18:3]));
				check_field("crc_received",   32'(want.crc_received),
				            32'(m_axis_tdata[34:19]));
				check_field("frame_length",   32'(want.frame_length),
				            32'(m_axis_tdata[42:35]));
				check_field("padding",        0,
				            32'(m_axis_tdata[47:43]));
			end
		end
	end

	// ------------------------------------------------------------------------
	// Sequencer: directed frames, then phases of random frames, each phase
	// under fresh register values written while the block is idle.
	// ------------------------------------------------------------------------
	initial begin
		int phase_no;
		int phase_bytes;
		int frames;
		int random_bytes;

		phase_no     = 0;
		random_bytes = 0;
		wait (arst_n);
		@(posedge clk);

		// reset register values: all marks zero, minimum length five
		build_frame(6, FLAW_NONE);
		push_bytes(0, 5);
		wait_drained();

		// a write to a non-existent index must change nothing
		write_reg(REG_SPARE, 8'h5A);
		set_config(8'hFF, 8'h00, 8'hFF, 8'd3);

		// lone final byte: too short
		build_frame(1, FLAW_NONE);
		push_bytes(0, 0);
		// four bytes: empty CRC span, trailer overlaps the address byte
		build_frame(4, FLAW_NONE);
		push_bytes(0, 3);
		build_frame(4, FLAW_START);
		push_bytes(0, 3);
		build_frame(4, FLAW_END);
		push_bytes(0, 3);
		build_frame(4, FLAW_ADDRESS);
		push_bytes(0, 3);
		// shortest frame with a real CRC span
		build_frame(5, FLAW_NONE);
		push_bytes(0, 4);
		wait_drained();

		// end mark changed part-way through a frame, with the block idle
		build_frame(6, FLAW_NONE);
		push_bytes(0, 2);
		wait_drained();
		write_reg(fvc_pkg::REG_END_MARK, ~mirror_cfg.end_mark);
		cfg_valid <= 1'b0;
		frame_buf[5] = mirror_cfg.end_mark;
		push_bytes(3, 5);
		wait_drained();

		while (random_bytes < ITEM_TARGET) begin
			phase_no++;
			hold_phase  = (phase_no == 2);
			steady_flow = (phase_no == 4);
			if (phase_no == 1) begin
				// largest minimum length: only a full 255-byte frame gets checked
				set_config(pick_mark(), pick_mark(), pick_mark(), 8'd254);
				build_frame(255, FLAW_NONE);
				push_bytes(0, 254);
				random_bytes += frame_buf.size();
				build_frame(40, FLAW_NONE);
				push_bytes(0, 39);
				random_bytes += frame_buf.size();
				build_frame(255, FLAW_CRC);
				push_bytes(0, 254);
				random_bytes += frame_buf.size();
			end else begin
				set_config(pick_mark(), pick_mark(), pick_mark(),
				           (phase_no == 2) ? 8'd3 : pick_min());
				// over-long frames: well-formed once, garbage once
				if (phase_no == 3 || phase_no == 7) begin
					build_frame($urandom_range(300, 256),
					            (phase_no == 3) ? FLAW_NONE : FLAW_GARBLED);
					push_bytes(0, frame_buf.size() - 1);
					random_bytes += frame_buf.size();
				end
				phase_bytes = 0;
				frames      = 0;
				while (phase_bytes < 120 && !(mirror_cfg.min_length > 24 && frames >= 2)) begin
					phase_bytes += queue_random_frame();
					frames++;
				end
				random_bytes += phase_bytes;
			end
			wait_drained();
			hold_phase  = 1'b0;
			steady_flow = 1'b0;
		end

		if (error_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
